FILE: hw/rtl/ttlq_pkg.sv
// ----------------------------------------------------------------------------
// ttlq_pkg
// Shared types and codes for the TTL-grouped timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ttlq_pkg;

  localparam int TIME_W = 48;
  localparam int KEY_W  = 32;
  localparam int TTL_W  = 32;
  localparam int PAD_W  = 16;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int CCNT_W = 4;
  localparam int N_W    = 6;
  localparam logic [N_W-1:0] N_LAST = 6'd63;

  localparam logic [ACT_W-1:0] ACT_SET   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEL   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWEEP = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FRD,
    OP_FCMP,
    OP_URD,
    OP_UCLS,
    OP_ULINK,
    OP_UHEAD,
    OP_CLR,
    OP_CSRCH,
    OP_PICK,
    OP_PUSH,
    OP_SCAN,
    OP_EMIT,
    OP_PSEL,
    OP_HSEL,
    OP_SWLD,
    OP_SWSTEP,
    OP_RESMISS
  } dp_op_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             hit;
    logic             scnt_last;
    logic             cidx_last;
    logic             pick_fail;
    logic             any;
    logic             sw_pop;
    logic             sweep_more;
    logic             out_free;
    logic             n_zero;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_FRD,
    S_FCMP,
    S_URD,
    S_UCLS,
    S_ULINK,
    S_UHEAD,
    S_CINIT,
    S_CSRCH,
    S_PICK,
    S_PUSH,
    S_SINIT,
    S_SCAN,
    S_EMIT,
    S_PINIT,
    S_PSCAN,
    S_PSEL,
    S_PHEAD,
    S_SWLD,
    S_SW
  } ctrl_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ttlq_ram.sv
// ----------------------------------------------------------------------------
// ttlq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttlq_ctrl.sv
// ----------------------------------------------------------------------------
// ttlq_ctrl
// Sequencer: steps the datapath through key search, unlink, class search,
// push, class scan, pop selection, sweep steps and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlq_ctrl
  import ttlq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_op_t     op
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority case (st.action)
          ACT_SET, ACT_DEL, ACT_READ: state_next = S_FRD;
          ACT_POP:                    state_next = S_PINIT;
          ACT_SWEEP:                  state_next = S_SWLD;
          default: begin
            op         = OP_RESMISS;
            state_next = S_SINIT;
          end
        endcase
      end
      S_FRD: begin
        op         = OP_FRD;
        state_next = S_FCMP;
      end
      S_FCMP: begin
        op = OP_FCMP;
        if (st.hit) begin
          state_next = (st.action == ACT_READ) ? S_SINIT : S_URD;
        end else if (st.scnt_last) begin
          state_next = (st.action == ACT_SET) ? S_CINIT : S_SINIT;
        end else begin
          state_next = S_FRD;
        end
      end
      S_URD: begin
        op         = OP_URD;
        state_next = S_UCLS;
      end
      S_UCLS: begin
        op         = OP_UCLS;
        state_next = S_ULINK;
      end
      S_ULINK: begin
        op         = OP_ULINK;
        state_next = S_UHEAD;
      end
      S_UHEAD: begin
        op         = OP_UHEAD;
        state_next = (st.action == ACT_SET) ? S_CINIT : S_SINIT;
      end
      S_CINIT: begin
        op         = OP_CLR;
        state_next = S_CSRCH;
      end
      S_CSRCH: begin
        op = OP_CSRCH;
        if (st.cidx_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        op         = OP_PICK;
        state_next = st.pick_fail ? S_SINIT : S_PUSH;
      end
      S_PUSH: begin
        op         = OP_PUSH;
        state_next = S_SINIT;
      end
      S_SINIT: begin
        op         = OP_CLR;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (st.cidx_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          op         = OP_EMIT;
          state_next = st.sweep_more ? S_SWLD : S_IDLE;
        end
      end
      S_PINIT: begin
        op         = OP_CLR;
        state_next = S_PSCAN;
      end
      S_PSCAN: begin
        op = OP_SCAN;
        if (st.cidx_last) begin
          state_next = S_PSEL;
        end
      end
      S_PSEL: begin
        op         = OP_PSEL;
        state_next = st.any ? S_PHEAD : S_SINIT;
      end
      S_PHEAD: begin
        op         = OP_HSEL;
        state_next = S_URD;
      end
      S_SWLD: begin
        op         = OP_SWLD;
        state_next = S_SW;
      end
      S_SW: begin
        op = OP_SWSTEP;
        if (st.sw_pop) begin
          state_next = S_URD;
        end else if (st.cidx_last) begin
          state_next = st.n_zero ? S_SINIT : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttlq_dp.sv
// ----------------------------------------------------------------------------
// ttlq_dp
// Datapath: slot RAMs, class FIFO pointers, search and scan registers,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlq_dp
  import ttlq_pkg::*;
#(
  parameter int ENTRIES = 32,
  parameter int CLASSES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_op_t            op,
  output dp_status_t        st,
  input  logic              cfg_we,
  input  logic [PAD_W-1:0]  cfg_wdata,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key,
  input  logic [TTL_W-1:0]  ttl,
  input  logic [TIME_W-1:0] now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [KEY_W-1:0]  out_key,
  output logic [TIME_W-1:0] expiry,
  output logic              last,
  output logic              next_valid,
  output logic [TIME_W-1:0] next_expiry,
  output logic [CCNT_W-1:0] class_count
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int LW   = $clog2(ENTRIES + 1);
  localparam int CNTW = $clog2(CLASSES + 1);
  localparam int DW   = KEY_W + TIME_W + CW;

  // request
  logic [ACT_W-1:0]  req_act;
  logic [KEY_W-1:0]  req_key;
  logic [TTL_W-1:0]  req_ttl;
  logic [TIME_W-1:0] req_exp;
  logic [TIME_W-1:0] thr;
  logic [PAD_W-1:0]  pad;
  logic [TIME_W:0]   thr_sum;

  // slot side
  logic [ENTRIES-1:0] used;
  logic [AW-1:0]      scnt;
  logic [AW-1:0]      sel;
  logic [AW-1:0]      nxt;
  logic [AW-1:0]      prv;
  logic [AW-1:0]      ffree;
  logic               ffree_ok;
  logic               old_found;
  logic               head_upd;

  // class side
  logic [TTL_W-1:0]  cls_ttl  [CLASSES];
  logic [AW-1:0]     cls_head [CLASSES];
  logic [AW-1:0]     cls_tail [CLASSES];
  logic [LW-1:0]     cls_len  [CLASSES];
  logic [TIME_W-1:0] cls_hexp [CLASSES];
  logic [CW-1:0]     cidx;
  logic [CW-1:0]     cidx_inc;
  logic [CW-1:0]     swc;
  logic              match_f;
  logic [CW-1:0]     match_c;
  logic              free_f;
  logic [CW-1:0]     free_c;
  logic              best_f;
  logic [CW-1:0]     best_c;
  logic [TIME_W-1:0] best_exp;
  logic [CNTW-1:0]   cnt;
  logic              anyexp;
  logic [N_W-1:0]    n;

  // pending result
  logic [STAT_W-1:0] res_st;
  logic [KEY_W-1:0]  res_key;
  logic [TIME_W-1:0] res_exp;

  // RAM ports
  logic          d_we;
  logic [AW-1:0] d_waddr;
  logic [DW-1:0] d_wdata;
  logic          d_re;
  logic [AW-1:0] d_raddr;
  logic [DW-1:0] d_rdata;
  logic          n_we;
  logic [AW-1:0] n_waddr;
  logic [AW-1:0] n_wdata;
  logic [AW-1:0] n_rdata;
  logic          p_we;
  logic [AW-1:0] p_waddr;
  logic [AW-1:0] p_wdata;
  logic [AW-1:0] p_rdata;
  logic          lp_re;

  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_exp;
  logic [CW-1:0]     rd_cls;

  logic cidx_last;
  logic cur_open;
  logic pick_fail;
  logic sweep_more;
  logic out_free;

  assign rd_key = d_rdata[DW-1 -: KEY_W];
  assign rd_exp = d_rdata[CW +: TIME_W];
  assign rd_cls = d_rdata[CW-1:0];

  assign cidx_last  = (cidx == CW'(CLASSES - 1));
  assign cidx_inc   = cidx_last ? '0 : cidx + CW'(1);
  assign cur_open   = (cls_len[cidx] != '0);
  assign pick_fail  = !(old_found || ffree_ok) || !(match_f || free_f);
  assign sweep_more = (req_act == ACT_SWEEP) && anyexp && (n != N_LAST);
  assign out_free   = !out_valid || out_ready;
  assign thr_sum    = {1'b0, now} + (TIME_W + 1)'(pad);

  always_comb begin
    ffree    = '0;
    ffree_ok = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        ffree    = AW'(i);
        ffree_ok = 1'b1;
      end
    end
  end

  always_comb begin
    st            = '0;
    st.action     = req_act;
    st.hit        = used[scnt] && (rd_key == req_key);
    st.scnt_last  = (scnt == AW'(ENTRIES - 1));
    st.cidx_last  = cidx_last;
    st.pick_fail  = pick_fail;
    st.any        = best_f;
    st.sw_pop     = cur_open && (cls_hexp[cidx] <= thr);
    st.sweep_more = sweep_more;
    st.out_free   = out_free;
    st.n_zero     = (n == '0);
  end

  // RAM port steering
  always_comb begin
    d_re    = 1'b0;
    d_raddr = sel;
    lp_re   = (op == OP_URD);
    d_we    = (op == OP_PUSH);
    d_waddr = sel;
    d_wdata = {req_key, req_exp, cidx};
    n_we    = 1'b0;
    n_waddr = prv;
    n_wdata = nxt;
    p_we    = 1'b0;
    p_waddr = nxt;
    p_wdata = prv;
    unique case (op)
      OP_FRD: begin
        d_re    = 1'b1;
        d_raddr = scnt;
      end
      OP_URD: begin
        d_re = 1'b1;
      end
      OP_ULINK: begin
        d_re    = 1'b1;
        d_raddr = nxt;
        if (cls_len[cidx] != LW'(1)) begin
          n_we = (cls_head[cidx] != sel);
          p_we = (cls_tail[cidx] != sel);
        end
      end
      OP_PUSH: begin
        if (cur_open) begin
          n_we    = 1'b1;
          n_waddr = cls_tail[cidx];
          n_wdata = sel;
          p_we    = 1'b1;
          p_waddr = sel;
          p_wdata = cls_tail[cidx];
        end
      end
      default: ;
    endcase
  end

  ttlq_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  ttlq_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_next (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(lp_re), .raddr(sel), .rdata(n_rdata)
  );

  ttlq_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_prev (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(lp_re), .raddr(sel), .rdata(p_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      cls_len   <= '{default: '0};
      out_valid <= 1'b0;
      pad       <= '0;
    end else begin
      if (cfg_we) begin
        pad <= cfg_wdata;
      end
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        OP_UCLS: used[sel] <= 1'b0;
        OP_ULINK: cls_len[cidx] <= cls_len[cidx] - LW'(1);
        OP_PUSH: begin
          used[sel]     <= 1'b1;
          cls_len[cidx] <= cls_len[cidx] + LW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        req_act   <= action;
        req_key   <= key;
        req_ttl   <= ttl;
        req_exp   <= now + TIME_W'(ttl);
        thr       <= thr_sum[TIME_W] ? '1 : thr_sum[TIME_W-1:0];
        scnt      <= '0;
        old_found <= 1'b0;
        swc       <= '0;
        n         <= '0;
      end
      OP_FCMP: begin
        if (st.hit) begin
          sel       <= scnt;
          old_found <= 1'b1;
          res_st    <= ST_OK;
          res_key   <= req_key;
          res_exp   <= rd_exp;
        end else if (st.scnt_last) begin
          res_st  <= ST_MISS;
          res_key <= req_key;
          res_exp <= '0;
        end else begin
          scnt <= scnt + AW'(1);
        end
      end
      OP_UCLS: begin
        cidx     <= rd_cls;
        res_st   <= ST_OK;
        res_key  <= rd_key;
        res_exp  <= rd_exp;
        nxt      <= n_rdata;
        prv      <= p_rdata;
        head_upd <= 1'b0;
      end
      OP_ULINK: begin
        if (cls_len[cidx] != LW'(1)) begin
          if (cls_head[cidx] == sel) begin
            cls_head[cidx] <= nxt;
            head_upd       <= 1'b1;
          end
          if (cls_tail[cidx] == sel) begin
            cls_tail[cidx] <= prv;
          end
        end
      end
      OP_UHEAD: begin
        if (head_upd) begin
          cls_hexp[cidx] <= rd_exp;
        end
      end
      OP_CLR: begin
        cidx    <= '0;
        match_f <= 1'b0;
        free_f  <= 1'b0;
        best_f  <= 1'b0;
        cnt     <= '0;
        anyexp  <= 1'b0;
      end
      OP_CSRCH: begin
        if (cur_open && (cls_ttl[cidx] == req_ttl) && !match_f) begin
          match_f <= 1'b1;
          match_c <= cidx;
        end
        if (!cur_open && !free_f) begin
          free_f <= 1'b1;
          free_c <= cidx;
        end
        cidx <= cidx_inc;
      end
      OP_PICK: begin
        if (pick_fail) begin
          res_st  <= ST_FULL;
          res_key <= req_key;
          res_exp <= '0;
        end else begin
          cidx <= match_f ? match_c : free_c;
          if (!old_found) begin
            sel <= ffree;
          end
        end
      end
      OP_PUSH: begin
        if (!cur_open) begin
          cls_head[cidx] <= sel;
          cls_hexp[cidx] <= req_exp;
          cls_ttl[cidx]  <= req_ttl;
        end
        cls_tail[cidx] <= sel;
        res_st         <= ST_OK;
        res_key        <= req_key;
        res_exp        <= req_exp;
      end
      OP_SCAN: begin
        if (cur_open) begin
          cnt <= cnt + CNTW'(1);
          if (!best_f || (cls_hexp[cidx] < best_exp)) begin
            best_f   <= 1'b1;
            best_c   <= cidx;
            best_exp <= cls_hexp[cidx];
          end
          if (cls_hexp[cidx] <= thr) begin
            anyexp <= 1'b1;
          end
        end
        cidx <= cidx_inc;
      end
      OP_EMIT: begin
        status      <= res_st;
        out_key     <= res_key;
        expiry      <= res_exp;
        last        <= !sweep_more;
        next_valid  <= best_f;
        next_expiry <= best_f ? best_exp : '0;
        class_count <= CCNT_W'(cnt);
        n           <= n + N_W'(1);
      end
      OP_PSEL: begin
        if (best_f) begin
          cidx <= best_c;
        end else begin
          res_st  <= ST_MISS;
          res_key <= '0;
          res_exp <= '0;
        end
      end
      OP_HSEL: sel <= cls_head[cidx];
      OP_SWLD: cidx <= swc;
      OP_SWSTEP: begin
        if (st.sw_pop) begin
          sel <= cls_head[cidx];
        end else if (cidx_last) begin
          if (n == '0) begin
            res_st  <= ST_MISS;
            res_key <= '0;
            res_exp <= '0;
          end
        end else begin
          cidx <= cidx_inc;
          swc  <= swc + CW'(1);
        end
      end
      OP_RESMISS: begin
        res_st  <= ST_MISS;
        res_key <= req_key;
        res_exp <= '0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ttl_grouped_timer_queue.sv
// ----------------------------------------------------------------------------
// ttl_grouped_timer_queue
// Keyed timer store; timers sharing a TTL share one FIFO class. Set, delete,
// read, pop earliest and pop-all-expired requests.
//
//   channel  signals                                       direction
//   in       in_valid/in_ready, action, key, ttl, now      request in
//   out      out_valid/out_ready, status, out_key, expiry,
//            last, next_valid, next_expiry, class_count    result out
//   cfg      cfg_we, cfg_wdata (expiry_padding)            write only
//
// One request at a time. A key search reads and then compares each slot in turn
// (slot RAM read, then compare); each pass over the classes steps through them
// in turn; an unlink runs the read, class, link and head steps. Set unlinks a
// key that is already stored before pushing it again.
// Reset clears slot-used bits, class lengths and the padding; no clearing pass.
// A stalled output holds the sequencer only when a new result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_grouped_timer_queue
  import ttlq_pkg::*;
#(
  parameter int ENTRIES = 32,
  parameter int CLASSES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PAD_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [KEY_W-1:0]  key,
  input  logic [TTL_W-1:0]  ttl,
  input  logic [TIME_W-1:0] now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [KEY_W-1:0]  out_key,
  output logic [TIME_W-1:0] expiry,
  output logic              last,
  output logic              next_valid,
  output logic [TIME_W-1:0] next_expiry,
  output logic [CCNT_W-1:0] class_count
);

  dp_op_t     op;
  dp_status_t st;

  ttlq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .st, .op
  );

  ttlq_dp #(.ENTRIES(ENTRIES), .CLASSES(CLASSES)) u_dp (
    .clk, .rst, .op, .st, .cfg_we, .cfg_wdata,
    .action, .key, .ttl, .now,
    .out_valid, .out_ready, .status, .out_key, .expiry, .last,
    .next_valid, .next_expiry, .class_count
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_no_next_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !next_valid |-> next_expiry == '0)
    else $error("next_expiry set with no pending timer");

  a_fail_no_expiry: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> expiry == '0)
    else $error("expiry reported on a failed request");

  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> last)
    else $error("full status not final");

endmodule

`default_nettype wire
